[rtl/http_path_acceptance_checker_macros.svh]
// Assertion macros for the HTTP path acceptance checker.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef HTTP_PATH_ACCEPTANCE_CHECKER_MACROS_SVH
`define HTTP_PATH_ACCEPTANCE_CHECKER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define HPAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define HPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hpac_pkg.sv]
// Constants and types for the HTTP path acceptance checker.
// No dependencies.
package hpac_pkg;

  localparam int unsigned POS_W  = 4;
  localparam int unsigned LEFT_W = 3;
  localparam int unsigned DEC_W  = 32;

  // Length of the well-known prefix; byte position saturates here
  localparam logic [POS_W-1:0] WK_LEN = 4'd13;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Outcome of judging one decoded character
  typedef struct packed {
    logic prev_slash;
    logic seen;
    logic reject;
    logic pending;
  } char_eval_t;

  // Bytes of "/.well-known/" by position
  function automatic logic [7:0] wk_byte(input logic [POS_W-1:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h2F; // '/'
      4'd1:    r = 8'h2E; // '.'
      4'd2:    r = 8'h77; // 'w'
      4'd3:    r = 8'h65; // 'e'
      4'd4:    r = 8'h6C; // 'l'
      4'd5:    r = 8'h6C; // 'l'
      4'd6:    r = 8'h2D; // '-'
      4'd7:    r = 8'h6B; // 'k'
      4'd8:    r = 8'h6E; // 'n'
      4'd9:    r = 8'h6F; // 'o'
      4'd10:   r = 8'h77; // 'w'
      4'd11:   r = 8'h6E; // 'n'
      4'd12:   r = 8'h2F; // '/'
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

[rtl/http_path_acceptance_checker.sv]
// HTTP path acceptance checker: one path byte per word, verdict with the last byte.
// Depends on hpac_pkg and http_path_acceptance_checker_macros.svh.
//
//   channel   | dir | tdata                     | tlast
//   ----------+-----+---------------------------+---------
//   s_axis    | in  | [7:0] path_byte           | is_last
//   m_axis    | out | [0] acceptable, rest zero | -
//
// Each byte is held in the input register, where it is decoded and judged; the verdict
// is loaded into the result register and offered on m_axis once the last byte leaves it.
// A new byte is accepted every cycle; only a last byte can stall, when the
// result register is still full and m_axis_tready_i is low.
// rst_ni empties the byte register (its valid flag), clears the result register and the path state.
`include "http_path_acceptance_checker_macros.svh"

module http_path_acceptance_checker
  import hpac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] path_byte
  input  logic       s_axis_tlast_i,  // is_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [0] acceptable, [7:1] zero
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Path state
  logic              psl_q, psl_d;
  logic              seen_q, seen_d;
  logic              rej_q, rej_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              pm_q, pm_d;
  logic              exc_q, exc_d;
  logic [DEC_W-1:0]  dec_q, dec_d;
  logic [LEFT_W-1:0] left_q, left_d;

  // Result register
  logic out_valid_q;
  logic out_ok_q;
  logic ok_d;

  logic proc;
  logic s_acc;

  // Character judge inputs
  logic             tc_take;
  logic [DEC_W-1:0] tc_x;
  logic             tc_psl;
  logic             tc_seen;
  char_eval_t       tc;

  logic             cont;
  logic [DEC_W-1:0] dec_shift;
  logic [LEFT_W-1:0] left_dec;
  logic             full;

  // Advance the held word unless it is a last byte blocked by a full result
  assign proc  = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_ok_q};

  assign cont      = (in_byte_q[7:6] == 2'b10);
  assign dec_shift = {dec_q[DEC_W-7:0], in_byte_q[5:0]};
  assign left_dec  = left_q - 3'd1;

  // Decode UTF-8 and pick the character to judge
  always_comb begin
    psl_d   = psl_q;
    seen_d  = seen_q;
    dec_d   = dec_q;
    left_d  = left_q;
    tc_take = 1'b0;
    tc_x    = {24'b0, in_byte_q};
    tc_psl  = psl_q;
    tc_seen = seen_q;
    if (left_q != '0 && cont) begin
      // continue the open sequence
      dec_d  = dec_shift;
      left_d = left_dec;
      tc_x   = dec_shift;
      tc_take = (left_dec == '0);
    end else begin
      // a broken sequence leaves plain characters behind
      if (left_q != '0) begin
        tc_psl  = 1'b0;
        tc_seen = 1'b1;
        psl_d   = 1'b0;
        seen_d  = 1'b1;
        left_d  = '0;
        dec_d   = '0;
      end
      if (in_byte_q[7:6] == 2'b11) begin
        if (in_byte_q[5] == 1'b0) begin
          dec_d  = {27'b0, in_byte_q[4:0]};
          left_d = 3'd1;
        end else if (in_byte_q[4] == 1'b0) begin
          dec_d  = {28'b0, in_byte_q[3:0]};
          left_d = 3'd2;
        end else if (in_byte_q[3] == 1'b0) begin
          dec_d  = {29'b0, in_byte_q[2:0]};
          left_d = 3'd3;
        end else if (in_byte_q[2] == 1'b0) begin
          dec_d  = {30'b0, in_byte_q[1:0]};
          left_d = 3'd4;
        end else begin
          dec_d  = {30'b0, in_byte_q[1:0]};
          left_d = 3'd5;
        end
      end else begin
        tc_take = 1'b1;
      end
    end
  end

  // Judge one character against the slash and dot rules
  always_comb begin
    logic is_dot;
    logic is_slash;
    is_dot   = (tc_x == {24'b0, CH_DOT});
    is_slash = (tc_x == {24'b0, CH_SLASH}) || (tc_x == {24'b0, CH_BSLASH});
    tc.prev_slash = tc_psl;
    tc.seen       = tc_seen;
    tc.reject     = rej_q;
    tc.pending    = exc_q;
    if (tc_take) begin
      if (tc_psl && is_dot) begin
        if (pos_q <= 4'd1) tc.pending = 1'b1;
        else tc.reject = 1'b1;
      end
      if (tc_psl && is_slash && tc_seen) tc.reject = 1'b1;
      tc.prev_slash = is_slash;
      tc.seen       = 1'b1;
    end
  end

  // Track the prefix and the raw byte position, form the verdict
  always_comb begin
    pm_d = pm_q;
    if (pos_q < WK_LEN && in_byte_q != wk_byte(pos_q)) pm_d = 1'b0;
    pos_d = (pos_q < WK_LEN) ? pos_q + 4'd1 : pos_q;
    rej_d = tc.reject;
    exc_d = tc.pending;
    full  = pm_d && (pos_d == WK_LEN);
    ok_d  = !rej_d && !(exc_d && !full);
  end

  // Hold the incoming word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Advance the path state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psl_q  <= 1'b1;
      seen_q <= 1'b0;
      rej_q  <= 1'b0;
      pos_q  <= '0;
      pm_q   <= 1'b1;
      exc_q  <= 1'b0;
      dec_q  <= '0;
      left_q <= '0;
    end else if (proc) begin
      if (in_last_q) begin
        psl_q  <= 1'b1;
        seen_q <= 1'b0;
        rej_q  <= 1'b0;
        pos_q  <= '0;
        pm_q   <= 1'b1;
        exc_q  <= 1'b0;
        dec_q  <= '0;
        left_q <= '0;
      end else begin
        psl_q  <= tc_take ? tc.prev_slash : psl_d;
        seen_q <= tc_take ? tc.seen : seen_d;
        rej_q  <= rej_d;
        pos_q  <= pos_d;
        pm_q   <= pm_d;
        exc_q  <= exc_d;
        dec_q  <= dec_d;
        left_q <= left_d;
      end
    end
  end

  // Load the verdict, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
    end else if (proc && in_last_q) begin
      out_valid_q <= 1'b1;
      out_ok_q    <= ok_d;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  `HPAC_ASSERT(a_pos_range, pos_q <= WK_LEN, "byte position past saturation")
  `HPAC_ASSERT(a_left_range, left_q <= 3'd5, "continuation count out of range")
  `HPAC_ASSERT_NEXT(a_clear_after_last, proc && in_last_q,
                    pos_q == '0 && left_q == '0 && !rej_q && !exc_q,
                    "path state not cleared after last byte")
  `HPAC_ASSERT_NEXT(a_held_word, in_valid_q && !proc,
                    in_valid_q && $stable(in_byte_q) && $stable(in_last_q),
                    "held byte lost while stalled")
  `HPAC_ASSERT(a_result_source, !$rose(out_valid_q) || $past(proc && in_last_q),
               "verdict without a last byte")

endmodule

[tb/path_verdict_checker.sv]
// Checker for the HTTP path acceptance checker: tracks every byte accepted on s_axis,
// predicts the verdict of each path and compares it with the words leaving m_axis.
// Depends on hpac_pkg for widths and character codes.
`timescale 1ns / 1ps

module path_verdict_checker
  import hpac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [7:0] path_byte
  input  logic        s_tlast_i,   // is_last
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,   // [0] acceptable, [7:1] zero
  output int unsigned fail_cnt_o,
  output int unsigned open_cnt_o
);

  localparam logic [8*13-1:0] WELL_KNOWN = "/.well-known/";

  // Predicted path state
  logic              prev_slash;
  logic              seen;
  logic              rejected;
  logic              prefix_ok;
  logic              dot_pending;
  logic [POS_W-1:0]  pos;
  logic [DEC_W-1:0]  dec_val;
  logic [LEFT_W-1:0] left;

  // Verdicts still to arrive, oldest first
  logic verdict_q[$];

  task automatic clear_path();
    prev_slash  = 1'b1;
    seen        = 1'b0;
    rejected    = 1'b0;
    prefix_ok   = 1'b1;
    dot_pending = 1'b0;
    pos         = '0;
    dec_val     = '0;
    left        = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_cnt_o++;
  endtask

  // Judge one decoded character at the position of its last byte
  task automatic judge_char(input logic [DEC_W-1:0] ch, input logic [POS_W-1:0] idx);
    logic [DEC_W-1:0] c;
    c = (ch == DEC_W'(CH_BSLASH)) ? DEC_W'(CH_SLASH) : ch;
    if (prev_slash) begin
      if (c == DEC_W'(CH_DOT)) begin
        if (idx <= 1) dot_pending = 1'b1;
        else rejected = 1'b1;
      end
      if (c == DEC_W'(CH_SLASH) && seen) rejected = 1'b1;
    end
    prev_slash = (c == DEC_W'(CH_SLASH));
    seen       = 1'b1;
  endtask

  // Advance the path state by one byte; queue a verdict on the last byte
  task automatic advance_path(input logic [7:0] b, input logic last);
    logic [POS_W-1:0] idx;
    logic             taken;
    logic             full;
    idx   = pos;
    taken = 1'b0;
    if (idx < WK_LEN && b != WELL_KNOWN[8*(12-int'(idx)) +: 8]) prefix_ok = 1'b0;

    if (left != 0) begin
      if (b[7:6] == 2'b10) begin
        dec_val = {dec_val[DEC_W-7:0], b[5:0]};
        left--;
        if (left == 0) judge_char(dec_val, idx);
        taken = 1'b1;
      end else begin
        // broken sequence: the open bytes count as an ordinary character
        prev_slash = 1'b0;
        seen       = 1'b1;
        left       = '0;
        dec_val    = '0;
      end
    end

    if (!taken) begin
      if (b >= 8'hFC) begin
        dec_val = DEC_W'(b[1:0]);
        left    = 3'd5;
      end else if (b >= 8'hF8) begin
        dec_val = DEC_W'(b[1:0]);
        left    = 3'd4;
      end else if (b >= 8'hF0) begin
        dec_val = DEC_W'(b[2:0]);
        left    = 3'd3;
      end else if (b >= 8'hE0) begin
        dec_val = DEC_W'(b[3:0]);
        left    = 3'd2;
      end else if (b >= 8'hC0) begin
        dec_val = DEC_W'(b[4:0]);
        left    = 3'd1;
      end else begin
        judge_char(DEC_W'(b), idx);
      end
    end

    if (pos < WK_LEN) pos++;

    if (last) begin
      full = prefix_ok && (pos == WK_LEN);
      verdict_q.push_back(!rejected && !(dot_pending && !full));
      clear_path();
    end
  endtask

  // Compare the outgoing word first, so a verdict queued this cycle is never taken early
  always @(posedge clk_i or negedge rst_ni) begin
    logic exp_ok;
    if (!rst_ni) begin
      clear_path();
      verdict_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict word 0x%02h with no path pending", m_tdata_i));
        end else begin
          exp_ok = verdict_q.pop_front();
          if (m_tdata_i !== {7'b0, exp_ok})
            report_mismatch($sformatf("verdict word 0x%02h, expected acceptable=%0d",
                                      m_tdata_i, exp_ok));
        end
      end
      if (s_tvalid_i && s_tready_i) advance_path(s_tdata_i, s_tlast_i);
    end
    open_cnt_o = verdict_q.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the testbench for the HTTP path acceptance checker: clock, reset, path stimulus
// and a randomly stalling receiver; path_verdict_checker does the prediction.
// Depends on hpac_pkg, path_verdict_checker and the block itself.
`timescale 1ns / 1ps

module tb_top
  import hpac_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned BYTE_TARGET = 1400;
  localparam int unsigned HOLD_CYCLES = 400;

  logic       clk_i;
  logic       rst_n;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;

  int unsigned fail_cnt;
  int unsigned open_cnt;
  int unsigned cycle_cnt;
  int unsigned bytes_sent;
  int unsigned paths;
  logic        rush;
  logic        src_calm;
  logic        snk_calm;
  logic        held;
  logic [7:0]  path_q[$];

  http_path_acceptance_checker i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  path_verdict_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .fail_cnt_o (fail_cnt),
    .open_cnt_o (open_cnt)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offer one word, called and returning at a falling edge
  task automatic send_word(input logic [7:0] b, input logic last);
    int gap;
    gap = (rush || src_calm) ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_path();
    for (int i = 0; i < path_q.size(); i++) send_word(path_q[i], i == path_q.size() - 1);
    path_q.delete();
    paths++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) path_q.push_back(s[i]);
  endtask

  // Append an n-byte UTF-8 form of v, keeping only the first keep continuation bytes
  task automatic push_utf8(input logic [31:0] v, input int n, input int keep);
    logic [7:0] lead;
    logic [31:0] hi;
    hi = v >> (6 * (n - 1));
    case (n)
      2:       lead = 8'hC0 | (hi[7:0] & 8'h1F);
      3:       lead = 8'hE0 | (hi[7:0] & 8'h0F);
      4:       lead = 8'hF0 | (hi[7:0] & 8'h07);
      5:       lead = 8'hF8 | (hi[7:0] & 8'h03);
      default: lead = 8'hFC | (hi[7:0] & 8'h03);
    endcase
    path_q.push_back(lead);
    for (int i = 0; i < keep; i++)
      path_q.push_back(8'h80 | 8'((v >> (6 * (n - 2 - i))) & 32'h3F));
  endtask

  // Code point for a multi-byte form: mostly the characters that matter
  function automatic logic [31:0] pick_point();
    case ($urandom_range(0, 3))
      0:       return 32'(CH_DOT);
      1:       return 32'(CH_SLASH);
      2:       return 32'(CH_BSLASH);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_piece();
    int n;
    case ($urandom_range(0, 9))
      0, 1: path_q.push_back(8'($urandom_range(0, 127)));
      2:    path_q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
      3:    path_q.push_back(CH_DOT);
      4, 5: begin
        n = $urandom_range(2, 6);
        push_utf8(pick_point(), n, n - 1);
      end
      6: begin
        // sequence broken by the next piece or by the end of the path
        n = $urandom_range(2, 6);
        push_utf8(pick_point(), n, $urandom_range(0, n - 2));
      end
      7:       path_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      8:       path_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      default: path_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic build_random_path();
    int pieces;
    if (!rush && $urandom_range(0, 7) == 0) begin
      // noise: raw bytes
      repeat ($urandom_range(1, 16)) path_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if (!rush && $urandom_range(0, 4) == 0) begin
        push_text("/.well-known/");
        if ($urandom_range(0, 3) == 0) path_q[$urandom_range(0, 12)] = 8'($urandom_range(0, 255));
      end else if ($urandom_range(0, 3) != 0) begin
        path_q.push_back(CH_SLASH);
      end
      pieces = rush ? $urandom_range(0, 1) : $urandom_range(0, 8);
      repeat (pieces) add_piece();
      if (path_q.size() == 0) add_piece();
    end
  endtask

  // Receiver: random stalls per word, one long hold-off while the sender rushes
  initial begin
    int gap;
    m_tready = 1'b0;
    snk_calm = 1'b0;
    held     = 1'b0;
    wait (rst_n);
    @(negedge clk_i);
    forever begin
      if (rush && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      gap = snk_calm ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 15) == 0) snk_calm = !snk_calm;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Sender and verdict
  initial begin
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tlast    = 1'b0;
    rush       = 1'b0;
    src_calm   = 1'b0;
    paths      = 0;
    bytes_sent = 0;
    rst_n      = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // well-known prefix in full: the early dot is forgiven
    push_text("/.well-known/");
    send_path();
    // backslash then dot, path too short for the exception
    path_q.push_back(CH_BSLASH);
    path_q.push_back(CH_DOT);
    send_path();
    // double slash
    push_text("//");
    send_path();
    // overlong two-byte dot after a slash
    path_q.push_back(CH_SLASH);
    path_q.push_back(8'hC0);
    path_q.push_back(8'hAE);
    send_path();
    // sequence broken by a slash, then a lead cut by the end
    path_q.push_back(8'hE0);
    path_q.push_back(CH_SLASH);
    path_q.push_back(8'hFF);
    send_path();
    // stray continuation byte, then a zero byte
    path_q.push_back(8'h80);
    path_q.push_back(8'h00);
    send_path();

    while (bytes_sent < BYTE_TARGET) begin
      if (paths == 60) rush = 1'b1;
      if (paths == 110) rush = 1'b0;
      build_random_path();
      send_path();
    end
    s_tvalid <= 1'b0;

    // drain, then allow the pipeline to settle
    while (open_cnt != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
